@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of the queue project.
// Depends on nothing; each file that asserts includes it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold on every clock edge outside reset.
`define SMPQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed in sorted queue checker");

// A condition in one cycle that requires a consequence in the next cycle.
`define SMPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed in sorted queue checker");

`endif

@@ hdl/smpq_pkg.sv @@
// Package of the sorted max-priority queue: request and result types,
// operation and status codes, and the control struct for the cell chain.
// Depends on nothing.
package smpq_pkg;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [31:0] removed_value;
    logic        removed_valid;
    status_e     status;
    logic [31:0] head_value;
    logic [4:0]  occupancy;
  } rsp_t;

  // Broadcast to every cell of the chain in the cycle a request is taken.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

@@ hdl/smpq_cell.sv @@
// One cell of the sorted chain: holds a single entry and moves it toward
// the tail on insert or toward the head on remove. Uses smpq_pkg.
module smpq_cell #(
  parameter int VALUE_BITS = 32
) (
  input  logic                    clk_i,
  input  smpq_pkg::cell_ctrl_t    ctrl_i,
  input  logic                    occ_i,
  input  logic [VALUE_BITS-1:0]   new_val_i,
  input  logic [VALUE_BITS-1:0]   prev_val_i,
  input  logic                    prev_keep_i,
  input  logic [VALUE_BITS-1:0]   next_val_i,
  output logic [VALUE_BITS-1:0]   val_o,
  output logic [VALUE_BITS-1:0]   val_next_o,
  output logic                    keep_o
);

  logic [VALUE_BITS-1:0] val_q, val_d;

  // An entry stays put on insert when it is stored and not below the new value,
  // so equal values keep arrival order.
  assign keep_o = occ_i && (val_q >= new_val_i);

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins && !keep_o) begin
      val_d = prev_keep_i ? new_val_i : prev_val_i;
    end else if (ctrl_i.rem) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o      = val_q;
  assign val_next_o = val_d;

endmodule

@@ hdl/sorted_max_priority_queue.sv @@
// Channel   | Direction | Handshake              | Payload
// request   | in        | start high, busy low   | req_i  (smpq_pkg::req_t)
// result    | out       | done_o for one cycle   | rsp_o  (smpq_pkg::rsp_t)
//
// A request is taken on start; its result appears on rsp_o with done_o
// in the following cycle, and a new request may be taken every cycle.
// The rate is set by the cell chain, where every cell compares and shifts
// its entry in the same cycle. Reset clears the entry count and the result
// strobe; entries are written before they are read. The receiver cannot
// stall, so busy stays low.
// Depends on smpq_pkg and smpq_cell.
module sorted_max_priority_queue #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  smpq_pkg::req_t req_i,
  output logic           done_o,
  output smpq_pkg::rsp_t rsp_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  logic                  take;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [VALUE_BITS-1:0] new_val;
  logic [VALUE_BITS+31:0] in_wide, rem_wide, head_wide;
  logic [CNT_W+4:0]      occ_wide;
  smpq_pkg::cell_ctrl_t  ctrl;
  smpq_pkg::rsp_t        rsp_q, rsp_d;
  logic                  done_q;

  logic [VALUE_BITS-1:0] cell_val  [CAPACITY];
  logic [VALUE_BITS-1:0] cell_next [CAPACITY];
  logic                  cell_keep [CAPACITY];

  assign busy = 1'b0;
  assign take = start && !busy;

  assign in_wide = {{VALUE_BITS{1'b0}}, req_i.value};
  assign new_val = in_wide[VALUE_BITS-1:0];

  assign ctrl.ins = take && (req_i.op == smpq_pkg::OP_INSERT) && (count_q < CAP_C);
  assign ctrl.rem = take && (req_i.op == smpq_pkg::OP_REMOVE) && (count_q != '0);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] prev_val, next_val;
    logic                  prev_keep;

    if (i == 0) begin : g_head
      assign prev_val  = new_val;
      assign prev_keep = 1'b0;
    end else begin : g_body
      assign prev_val  = cell_val[i-1];
      assign prev_keep = cell_keep[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_val = cell_val[i];
    end else begin : g_inner
      assign next_val = cell_val[i+1];
    end

    smpq_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (CNT_W'(i) < count_q),
      .new_val_i  (new_val),
      .prev_val_i (prev_val),
      .prev_keep_i(prev_keep),
      .next_val_i (next_val),
      .val_o      (cell_val[i]),
      .val_next_o (cell_next[i]),
      .keep_o     (cell_keep[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  assign rem_wide  = {32'b0, cell_val[0]};
  assign head_wide = {32'b0, cell_next[0]};
  assign occ_wide  = {5'b0, count_d};

  always_comb begin
    rsp_d.removed_value = ctrl.rem ? rem_wide[31:0] : 32'b0;
    rsp_d.removed_valid = ctrl.rem;
    rsp_d.status        = smpq_pkg::STATUS_OK;
    if (req_i.op == smpq_pkg::OP_INSERT && !ctrl.ins) begin
      rsp_d.status = smpq_pkg::STATUS_FULL;
    end else if (req_i.op == smpq_pkg::OP_REMOVE && !ctrl.rem) begin
      rsp_d.status = smpq_pkg::STATUS_EMPTY;
    end
    rsp_d.head_value = (count_d != '0) ? head_wide[31:0] : 32'b0;
    rsp_d.occupancy  = occ_wide[4:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

@@ hdl/smpq_checker.sv @@
// Port-level checker for the sorted max-priority queue, bound to the top level.
// Depends on smpq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module smpq_checker #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input smpq_pkg::rsp_t rsp_o
);

  logic        take;
  logic        small_cap;
  logic        narrow_val;
  logic        removing;
  logic        status_ok;
  logic        occ_ok;
  logic        order_arm;
  logic [31:0] rem_val;

  assign take       = start && !busy;
  assign small_cap  = (CAPACITY < 32);
  assign narrow_val = (VALUE_BITS <= 32);
  assign removing   = done_o && rsp_o.removed_valid;
  assign status_ok  = (rsp_o.status == smpq_pkg::STATUS_OK);
  assign occ_ok     = (rsp_o.occupancy <= 5'(CAPACITY)) &&
                      (rsp_o.occupancy != 5'd0 || rsp_o.head_value == 32'd0);
  assign order_arm  = narrow_val && removing;
  assign rem_val    = rsp_o.removed_value;

  // Every taken request yields exactly one result, in the next cycle.
  `SMPQ_ASSERT_NEXT(a_done_follows_take, clk_i, rst_ni, take, done_o)
  `SMPQ_ASSERT_NEXT(a_no_spurious_done, clk_i, rst_ni, !take, !done_o)

  // A removed entry is only reported together with an ok status.
  `SMPQ_ASSERT(a_removed_ok, clk_i, rst_ni, !removing || status_ok)

  // An empty queue reports a zero head, and occupancy never passes capacity.
  `SMPQ_ASSERT(a_empty_head, clk_i, rst_ni, !small_cap || !done_o || occ_ok)

  // Two removes in a row come out in non-increasing order.
  `SMPQ_ASSERT_NEXT(a_remove_order, clk_i, rst_ni, order_arm, !removing || rem_val <= $past(rem_val))

endmodule

bind sorted_max_priority_queue smpq_checker #(
  .CAPACITY  (CAPACITY),
  .VALUE_BITS(VALUE_BITS)
) u_smpq_checker (.*);
